// File: rtl/gcr_6and2_track_serialiser_defines.svh
// Assertion macros shared by the track serialiser RTL
`ifndef GCR_6AND2_TRACK_SERIALISER_DEFINES_SVH
`define GCR_6AND2_TRACK_SERIALISER_DEFINES_SVH

// same-cycle implication
`define GCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gcr serialiser: implication check failed");

// next-cycle implication
`define GCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gcr serialiser: next-cycle check failed");

`endif

// File: rtl/gcr62_pkg.sv
// Types, constants and encode tables for the 6-and-2 track serialiser
package gcr62_pkg;

    localparam logic [15:0] TRACK_BITS  = 16'd50304;
    localparam logic [15:0] LEAD_BITS   = 16'd160;
    localparam logic [11:0] SECTOR_BITS = 12'd3134;

    localparam logic [1:0] RD_A = 2'd0;
    localparam logic [1:0] RD_B = 2'd1;
    localparam logic [1:0] RD_C = 2'd2;

    localparam logic CFG_TRACK = 1'b0;
    localparam logic CFG_ALT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_RD0, S_RD1, S_RD2, S_RD3, S_STAGE, S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       stage;
        logic       emit;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic [1:0] rd_sel;
    } t_cmd;

    typedef struct packed {
        logic need_more;
        logic need_read;
        logic nib_hi;
        logic out_free;
    } t_status;

    localparam logic [7:0] GCR_MAP [64] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    localparam logic [7:0] HDR_PRO [3] = '{8'hd5, 8'haa, 8'h96};
    localparam logic [7:0] DAT_PRO [3] = '{8'hd5, 8'haa, 8'had};
    localparam logic [7:0] EPI     [3] = '{8'hde, 8'haa, 8'heb};

    localparam logic [7:0] VOLUME = 8'd254;

    function automatic logic [1:0] f_swap2(input logic [1:0] x);
        return {x[0], x[1]};
    endfunction

    function automatic logic [3:0] f_logical(input logic [3:0] sec, input logic alt);
        logic [6:0] v;
        v = alt ? {sec, 3'b000} : ({sec, 3'b000} - {3'b000, sec});
        for (int i = 0; i < 7; i++) begin
            if (v >= 7'd15) begin
                v = v - 7'd15;
            end
        end
        return (sec == 4'd15) ? 4'd15 : v[3:0];
    endfunction

endpackage

// File: rtl/gcr62_ram.sv
// Generic single-write, registered-read RAM
module gcr62_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/gcr62_ctrl.sv
// Sequencing state machine for the track serialiser
`include "gcr_6and2_track_serialiser_defines.svh"
module gcr62_ctrl import gcr62_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_op) n_state = S_FILL;
            end
            S_FILL: begin
                if (!i_status.need_more) n_state = S_EMIT;
                else if (i_status.need_read) n_state = S_RD0;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = i_status.nib_hi ? S_STAGE : S_RD2;
            S_RD2: n_state = S_RD3;
            S_RD3: n_state = S_STAGE;
            S_STAGE: n_state = S_FILL;
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = RD_A;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && !i_op;
            end
            S_FILL: o_cmd.stage = i_status.need_more && !i_status.need_read;
            S_RD0: o_cmd.rd_sel = RD_A;
            S_RD1: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.rd_sel = RD_B;
            end
            S_RD2: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.rd_sel = RD_C;
            end
            S_RD3: o_cmd.cap_c = 1'b1;
            S_STAGE: o_cmd.stage = 1'b1;
            S_EMIT: o_cmd.emit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    `GCR_ASSERT_IMP(a_stage_needed, i_clk, i_rst_n, o_cmd.stage, i_status.need_more)
    `GCR_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_status.out_free)
    `GCR_ASSERT_NXT(a_pull_fills, i_clk, i_rst_n, o_in_ready && i_in_valid && i_op, r_state == S_FILL)
endmodule

// File: rtl/gcr62_dp.sv
// Datapath: track store, element generator, bit staging and output register
`include "gcr_6and2_track_serialiser_defines.svh"
module gcr62_dp import gcr62_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    logic [15:0] r_pos, r_pbits;
    logic [11:0] r_off;
    logic [3:0]  r_sec;
    logic        r_tog;
    logic [4:0]  r_pcnt;
    logic [5:0]  r_prev;
    logic [7:0]  r_a, r_b, r_c;
    logic [5:0]  r_track;
    logic        r_alt;
    logic        r_oval, r_olast;
    logic [7:0]  r_obyte;

    logic [7:0]  w_val, w_field, w_rdata, w_nval;
    logic [3:0]  w_len;
    logic        w_sync, w_nib, w_lead, w_k342, w_nib_hi;
    logic [11:0] w_d, w_dk, w_noff;
    logic [2:0]  w_hk;
    logic [8:0]  w_k, w_roff;
    logic [5:0]  w_raw;
    logic [11:0] w_raddr;
    logic [4:0]  w_ncnt;
    logic [15:0] w_shifted, w_mask;
    logic        w_last;

    gcr62_ram #(.WIDTH(8), .DEPTH(4096)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr(i_address),
        .i_wdata(i_data),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_lead   = r_pos < LEAD_BITS;
    assign w_dk     = r_off - 12'd206;
    assign w_k      = w_dk[11:3];
    assign w_k342   = w_k == 9'd342;
    assign w_nib_hi = w_k >= 9'd86;

    assign w_raw = w_nib_hi ? r_a[7:2]
                 : {(w_k < 9'd84) ? f_swap2(r_c[1:0]) : 2'b00,
                    f_swap2(r_b[1:0]), f_swap2(r_a[1:0])};
    assign w_nval = w_k342 ? GCR_MAP[r_prev]
                  : GCR_MAP[w_raw ^ ((w_k == 9'd0) ? 6'd0 : r_prev)];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_A:    w_roff = w_nib_hi ? (w_k - 9'd86) : w_k;
            RD_B:    w_roff = w_k + 9'd86;
            RD_C:    w_roff = w_k + 9'd172;
            default: w_roff = w_k;
        endcase
    end
    assign w_raddr = {f_logical(r_sec, r_alt), w_roff[7:0]};

    always_comb begin
        w_val = 8'h00;
        w_len = 4'd8;
        w_sync = 1'b0;
        w_nib = 1'b0;
        w_d = '0;
        w_hk = '0;
        w_field = '0;
        if (w_lead) begin
            w_sync = 1'b1;
        end else if (r_off < 12'd24) begin
            w_val = HDR_PRO[r_off[4:3]];
        end else if (r_off < 12'd88) begin
            w_d = r_off - 12'd24;
            w_hk = w_d[5:3];
            case (w_hk[2:1])
                2'd0:    w_field = VOLUME;
                2'd1:    w_field = {2'b00, r_track};
                2'd2:    w_field = {4'b0000, r_sec};
                default: w_field = VOLUME ^ {2'b00, r_track} ^ {4'b0000, r_sec};
            endcase
            w_val = (w_hk[0] ? w_field : {1'b0, w_field[7:1]}) | 8'haa;
        end else if (r_off < 12'd112) begin
            w_d = r_off - 12'd88;
            w_val = EPI[w_d[4:3]];
        end else if (r_off < 12'd182) begin
            w_sync = 1'b1;
        end else if (r_off < 12'd206) begin
            w_d = r_off - 12'd182;
            w_val = DAT_PRO[w_d[4:3]];
        end else if (r_off < 12'd2950) begin
            w_nib = 1'b1;
            w_val = w_nval;
        end else if (r_off < 12'd2974) begin
            w_d = r_off - 12'd2950;
            w_val = EPI[w_d[4:3]];
        end else begin
            w_sync = 1'b1;
        end
        if (w_sync) begin
            w_val = r_tog ? 8'h00 : 8'hff;
            w_len = r_tog ? 4'd2 : 4'd8;
        end
    end

    assign w_noff = r_off + {8'b0, w_len};

    assign w_ncnt    = r_pcnt - 5'd8;
    assign w_shifted = r_pbits >> w_ncnt[2:0];
    assign w_mask    = (16'd1 << w_ncnt[3:0]) - 16'd1;
    assign w_last    = (r_pos >= TRACK_BITS) && (w_ncnt == 5'd0);

    assign o_status.need_more = (r_pcnt < 5'd8) && (r_pos < TRACK_BITS);
    assign o_status.need_read = w_nib && !w_k342;
    assign o_status.nib_hi    = w_nib_hi;
    assign o_status.out_free  = !r_oval || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) r_a <= w_rdata;
        if (i_cmd.cap_b) r_b <= w_rdata;
        if (i_cmd.cap_c) r_c <= w_rdata;
        if (i_cmd.emit) begin
            r_obyte <= w_shifted[7:0];
            r_olast <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_pbits <= '0; r_pcnt <= '0; r_prev <= '0;
            r_off <= '0; r_sec <= '0; r_tog <= 1'b0;
            r_track <= '0; r_alt <= 1'b0; r_oval <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRACK: r_track <= i_cfg_data;
                    CFG_ALT:   r_alt <= i_cfg_data[0];
                    default:   r_alt <= r_alt;
                endcase
            end
            if (i_cmd.emit) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
            if (i_cmd.load || (i_cmd.emit && w_last)) begin
                r_pos <= '0; r_pbits <= '0; r_pcnt <= '0; r_prev <= '0;
                r_off <= '0; r_sec <= '0; r_tog <= 1'b0;
            end else if (i_cmd.emit) begin
                r_pcnt <= w_ncnt;
                r_pbits <= r_pbits & w_mask;
            end else if (i_cmd.stage) begin
                r_pbits <= (w_len == 4'd8) ? {r_pbits[7:0], w_val}
                                          : {r_pbits[13:0], w_val[1:0]};
                r_pcnt <= r_pcnt + {1'b0, w_len};
                r_pos <= r_pos + {12'b0, w_len};
                r_tog <= r_tog ^ w_sync;
                if (!w_lead) begin
                    if (w_noff == SECTOR_BITS) begin
                        r_off <= '0;
                        r_sec <= r_sec + 4'd1;
                    end else begin
                        r_off <= w_noff;
                    end
                end
                if (w_nib && !w_k342) r_prev <= w_raw;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_byte  = r_obyte;
    assign o_last      = r_olast;

    `GCR_ASSERT_IMP(a_emit_full, i_clk, i_rst_n, i_cmd.emit, r_pcnt >= 5'd8)
    `GCR_ASSERT_NXT(a_wrap_restart, i_clk, i_rst_n, i_cmd.emit && w_last, r_pos == 16'd0)
    `GCR_ASSERT_IMP(a_stage_room, i_clk, i_rst_n, i_cmd.stage, r_pcnt < 5'd8)
endmodule

// File: rtl/gcr_6and2_track_serialiser.sv
// Top level of the 6-and-2 track serialiser
// Use: load a 4096-byte track (sixteen 256-byte logical sectors) with op 0
// beats on the input channel (address = sector * 256 + offset), then pull the
// encoded bitstream one byte per op 1 beat. Each pull yields one output beat,
// first stream bit in bit 7; o_last marks byte 6287, after which the stream
// restarts. Any load restarts the stream from its first bit.
// Configuration: index 0 sets the header track number, index 1 selects the
// alternate sector interleave; write only while the block is idle.
// Sequencing: a load is written straight into the track RAM and the block stays
// ready for the next beat. A pull takes bits from sync, marks or header directly,
// while a data nibble needs up to three reads of the track RAM (single read port,
// registered data) in sequence. The next beat is accepted from the cycle in which
// o_out_valid rises.
// Output: a result register holds the byte; the next pull is accepted while
// it waits, and the block stalls at its emit step if the receiver still has
// not taken the previous byte.
// Reset clears stream position, staging, configuration and the output valid flag;
// the track RAM is not cleared and must be loaded before pulling.
module gcr_6and2_track_serialiser import gcr62_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    gcr62_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_op      (i_op),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_in_ready(o_in_ready)
    );

    gcr62_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_address  (i_address),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );
endmodule

// File: verif/gcr_6and2_track_serialiser_tb.sv
// Self-checking testbench for the 6-and-2 track serialiser: loads tracks and pulls the bitstream
`timescale 1ns / 100ps

module gcr_6and2_track_serialiser_tb import gcr62_pkg::*;;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;
    localparam int STREAM_BITS = 50304;
    localparam int SEC_BITS = 3134;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = 1'b0;
    logic [11:0] i_address = '0;
    logic [7:0]  i_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [5:0]  i_cfg_data = '0;

    gcr_6and2_track_serialiser i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } t_beat;

    typedef struct {
        logic        op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        known;
        t_beat       exp_beat;
    } t_row;

    // predictor state
    logic [7:0]  trk [4096];
    int          bit_pos;
    logic [15:0] stage_bits;
    int          stage_cnt;
    logic [5:0]  prev_six;
    logic [5:0]  track_num;
    logic        alt_order;

    t_beat beat_q [$];
    int    n_mismatch = 0;
    longint cycles = 0;
    int    in_idle_pct = 0;
    int    out_idle_pct = 0;

    function automatic logic [7:0] rd_trk(int base, int idx);
        return trk[(base + idx) & 12'hfff];
    endfunction

    function automatic logic [1:0] bit_rev2(logic [1:0] x);
        return {x[0], x[1]};
    endfunction

    function automatic logic [5:0] six_of(int base, int n);
        logic [5:0] v;
        if (n >= 86) return 6'(rd_trk(base, n - 86) >> 2);
        v = {2'b00, bit_rev2(2'(rd_trk(base, n + 86))), bit_rev2(2'(rd_trk(base, n)))};
        if (n < 84) v[5:4] = bit_rev2(2'(rd_trk(base, n + 172)));
        return v;
    endfunction

    function automatic void sync_piece(int off, output logic [7:0] v, output int len);
        if (off % 10 < 8) begin
            v = 8'hff; len = 8;
        end else begin
            v = 8'h00; len = 2;
        end
    endfunction

    function automatic void stream_piece(int pos, output logic [7:0] v, output int len);
        int p, sec, off, k, logical;
        logic [7:0] fld;
        logic [5:0] raw;
        len = 8;
        if (pos < 160) begin
            sync_piece(pos, v, len);
            return;
        end
        p = pos - 160;
        sec = (p / SEC_BITS) & 15;
        off = p % SEC_BITS;
        if (off < 24) v = HDR_PRO[off / 8];
        else if (off < 88) begin
            k = (off - 24) / 8;
            case (k >> 1)
                0: fld = 8'd254;
                1: fld = {2'b00, track_num};
                2: fld = sec[7:0];
                default: fld = 8'd254 ^ {2'b00, track_num} ^ sec[7:0];
            endcase
            v = ((k & 1) ? fld : (fld >> 1)) | 8'haa;
        end else if (off < 112) v = EPI[(off - 88) / 8];
        else if (off < 182) sync_piece(off - 112, v, len);
        else if (off < 206) v = DAT_PRO[(off - 182) / 8];
        else if (off < 2950) begin
            k = (off - 206) / 8;
            logical = (sec == 15) ? 15 : (sec * (alt_order ? 8 : 7)) % 15;
            if (k == 342) v = GCR_MAP[prev_six];
            else begin
                raw = six_of(logical * 256, k);
                v = GCR_MAP[raw ^ (k == 0 ? 6'd0 : prev_six)];
                prev_six = raw;
            end
        end else if (off < 2974) v = EPI[(off - 2950) / 8];
        else sync_piece(off - 2974, v, len);
    endfunction

    function automatic void restart_stream();
        bit_pos = 0; stage_bits = '0; stage_cnt = 0; prev_six = '0;
    endfunction

    function automatic void predict_beat(logic op, logic [11:0] addr, logic [7:0] data);
        logic [7:0] v;
        int len;
        t_beat b;
        if (op == OP_LOAD) begin
            trk[addr] = data;
            restart_stream();
            return;
        end
        while (stage_cnt < 8 && bit_pos < STREAM_BITS) begin
            stream_piece(bit_pos, v, len);
            stage_bits = (stage_bits << len) | v;
            stage_cnt += len;
            bit_pos += len;
        end
        b.byte_val = 8'(stage_bits >> (stage_cnt - 8));
        stage_cnt -= 8;
        stage_bits &= (16'd1 << stage_cnt) - 16'd1;
        b.last = 1'b0;
        if (bit_pos >= STREAM_BITS && stage_cnt == 0) begin
            b.last = 1'b1;
            restart_stream();
        end
        beat_q.push_back(b);
    endfunction

    always @(posedge i_clk) begin
        t_beat e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beat_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected beat %h last %b", o_out_byte, o_last);
            end else begin
                e = beat_q.pop_front();
                if (e.byte_val !== o_out_byte || e.last !== o_last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("beat mismatch: exp %h/%b got %h/%b",
                                 e.byte_val, e.last, o_out_byte, o_last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // hold valid from the falling edge until the accepting rising edge
    task automatic send_beat(logic op, logic [11:0] addr, logic [7:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_address <= addr;
        i_data <= data;
        predict_beat(op, addr, data);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // send a pull whose result was already queued from the table
    task automatic send_known(t_row rw);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= rw.op;
        i_address <= rw.addr;
        i_data <= rw.data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (beat_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_TRACK) track_num = val;
        else alt_order = val[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // fill logical sector 0; pulls stay within physical sector 0 data
    task automatic fill_track(int mode);
        for (int a = 0; a < 256; a++) begin
            case (mode)
                0: send_beat(OP_LOAD, 12'(a), 8'h00);
                1: send_beat(OP_LOAD, 12'(a), 8'hff);
                default: send_beat(OP_LOAD, 12'(a), 8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic pull_n(int n);
        repeat (n) send_beat(OP_PULL, 12'd0, 8'($urandom_range(255)));
    endtask

    t_row rows [$];

    initial begin
        t_row r;
        in_idle_pct = 22;
        out_idle_pct = 58;
        restart_stream();
        track_num = 0;
        alt_order = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fill_track(2);
        // directed: lead sync bytes, with loads that restart the stream
        r = '{OP_PULL, 12'd0, 8'h00, 1'b1, '{8'hff, 1'b0}}; rows.push_back(r);
        r = '{OP_PULL, 12'hfff, 8'hff, 1'b1, '{8'h3f, 1'b0}}; rows.push_back(r);
        r = '{OP_PULL, 12'd0, 8'h00, 1'b0, '{8'h00, 1'b0}}; rows.push_back(r);
        r = '{OP_LOAD, 12'hfff, 8'hff, 1'b0, '{8'h00, 1'b0}}; rows.push_back(r);
        r = '{OP_PULL, 12'd0, 8'h00, 1'b1, '{8'hff, 1'b0}}; rows.push_back(r);
        r = '{OP_LOAD, 12'h000, 8'h00, 1'b0, '{8'h00, 1'b0}}; rows.push_back(r);
        foreach (rows[i]) begin
            if (rows[i].known && rows[i].op == OP_PULL) begin
                predict_beat(rows[i].op, rows[i].addr, rows[i].data);
                void'(beat_q.pop_back());
                // replace the predicted beat with the typed one
                beat_q.push_back(rows[i].exp_beat);
                send_known(rows[i]);
            end else send_beat(rows[i].op, rows[i].addr, rows[i].data);
        end
        pull_n(400);

        write_reg(CFG_TRACK, 6'd63);
        write_reg(CFG_ALT, 6'd1);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_ALT; i_cfg_data <= 6'h3e;
        alt_order = 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        write_reg(CFG_ALT, 6'd1);

        for (int ph = 0; ph < 3; ph++) begin
            in_idle_pct = (ph == 0) ? 58 : 0;
            out_idle_pct = (ph == 0) ? 22 : 0;
            write_reg(CFG_TRACK, 6'($urandom_range(39)));
            write_reg(CFG_ALT, 6'($urandom_range(1)));
            send_beat(OP_LOAD, 12'($urandom_range(255)), 8'($urandom_range(255)));
            pull_n(10);
            for (int i = 0; i < 6; i++) begin
                if ($urandom_range(3) == 0)
                    send_beat(OP_LOAD, 12'($urandom_range(4095)), 8'($urandom_range(255)));
                else pull_n($urandom_range(1, 6));
            end
            drain();
        end

        drain();
        if (n_mismatch == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
